// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the column substring filter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CSF_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle that implies a consequence in the next cycle.
`define CSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/csf_pkg.sv =====
// Shared types, constants and functions of the column substring filter.
package csf_pkg;

	localparam int PATTERN_CAP = 16;
	localparam int OUT_W       = 32;
	localparam int CFG_DATA_W  = 64;
	localparam int LEN_W       = 5;
	localparam int PIDX_W      = 4;

	typedef enum logic [1:0] {
		REG_PATTERN_LOW    = 2'd0,
		REG_PATTERN_HIGH   = 2'd1,
		REG_PATTERN_LENGTH = 2'd2,
		REG_FOLD_CASE      = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] pattern_low;
		logic [CFG_DATA_W-1:0] pattern_high;
		logic [LEN_W-1:0]      pattern_length;
		logic                  fold_case;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		logic [OUT_W-1:0] row;
	} result_t;

	// Folds ASCII upper case to lower case when enabled.
	function automatic logic [7:0] fold(input logic [7:0] c, input logic en);
		logic [7:0] r;
		r = c;
		if (en && c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

endpackage

// ===== hdl/csf_match.sv =====
// Character window, parallel pattern compare and per-entry state.
`include "assert_macros.svh"

module csf_match #(
	parameter int PATTERN_MAX = 16,
	parameter int ROW_BITS    = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [7:0]                  character,
	input  logic                        has_character,
	input  logic                        end_of_entry,
	input  csf_pkg::cfg_t               cfg,
	output csf_pkg::result_t            res
);

	localparam int CW = $clog2(PATTERN_MAX + 1);

	logic [CW-1:0]       cnt_q;
	logic                found_q;
	logic [ROW_BITS-1:0] row_q;

	logic [7:0]                  pat [csf_pkg::PATTERN_CAP];
	logic [7:0]                  seq [PATTERN_MAX];
	logic [csf_pkg::LEN_W-1:0]   len;
	logic [PATTERN_MAX-1:0]      eq;
	logic                        hit;
	logic                        found_now;
	logic [csf_pkg::OUT_W-1:0]   row_out;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			pat[i]     = cfg.pattern_low[8*i +: 8];
			pat[i + 8] = cfg.pattern_high[8*i +: 8];
		end
	end

	always_comb begin
		if (cfg.pattern_length > csf_pkg::LEN_W'(PATTERN_MAX)) begin
			len = csf_pkg::LEN_W'(PATTERN_MAX);
		end else begin
			len = cfg.pattern_length;
		end
	end

	// Window of earlier characters; seq[k] is the character k places before the new one.
	assign seq[0] = character;
	if (PATTERN_MAX > 1) begin : g_window
		logic [7:0] window_q [PATTERN_MAX-1];
		always_ff @(posedge clk) begin
			if (accept && has_character) begin
				window_q[0] <= character;
				for (int k = 1; k < PATTERN_MAX - 1; k++) begin
					window_q[k] <= window_q[k-1];
				end
			end
		end
		for (genvar k = 1; k < PATTERN_MAX; k++) begin : g_seq
			assign seq[k] = window_q[k-1];
		end
	end

	// Position k of the window is compared with pattern character len-1-k.
	always_comb begin
		logic [csf_pkg::PIDX_W-1:0] idx;
		for (int k = 0; k < PATTERN_MAX; k++) begin
			idx = csf_pkg::PIDX_W'(len - csf_pkg::LEN_W'(k) - csf_pkg::LEN_W'(1));
			eq[k] = (csf_pkg::LEN_W'(k) >= len) ||
				(csf_pkg::fold(seq[k], cfg.fold_case) ==
				 csf_pkg::fold(pat[idx], cfg.fold_case));
		end
	end

	assign hit = has_character && (len != '0) &&
		((6'(cnt_q) + 6'd1) >= 6'(len)) && (&eq);
	assign found_now = found_q || hit;

	if (ROW_BITS >= csf_pkg::OUT_W) begin : g_row_trunc
		assign row_out = row_q[csf_pkg::OUT_W-1:0];
	end else begin : g_row_ext
		assign row_out = {{(csf_pkg::OUT_W - ROW_BITS){1'b0}}, row_q};
	end

	assign res.valid = accept && end_of_entry && (found_now || (len == '0));
	assign res.row   = row_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			found_q <= 1'b0;
			row_q   <= '0;
		end else if (accept) begin
			if (end_of_entry) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
				if (row_q != '1) begin
					row_q <= row_q + ROW_BITS'(1);
				end
			end else begin
				found_q <= found_now;
				if (has_character && cnt_q != CW'(PATTERN_MAX)) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	`CSF_ASSERT(a_cnt_range, clk, arst_n, cnt_q <= CW'(PATTERN_MAX), "character count beyond pattern size")
	`CSF_ASSERT_NEXT(a_row_sat, clk, arst_n, row_q == '1, row_q == '1, "row counter left saturation")

endmodule

// ===== hdl/csf_out_fifo.sv =====
// Two-entry result queue that decouples input acceptance from the output side.
`include "assert_macros.svh"

module csf_out_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  csf_pkg::result_t          push,
	output logic                      not_full,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [csf_pkg::OUT_W-1:0] out_data
);

	logic [csf_pkg::OUT_W-1:0] mem_q [2];
	logic                      wr_ptr_q;
	logic                      rd_ptr_q;
	logic [1:0]                count_q;
	logic                      pop;

	assign not_full  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push.valid) - 2'(pop);
		end
	end

	`CSF_ASSERT(a_no_overflow, clk, arst_n, !(push.valid && count_q == 2'd2), "result pushed into a full queue")
	`CSF_ASSERT(a_count_range, clk, arst_n, count_q != 2'd3, "queue count out of range")

endmodule

// ===== hdl/column_substring_filter_unit.sv =====
// A result enters the result queue with the transaction that closes its entry and is presented from there.
// Throughput: one input transaction per cycle; input stalls only when two results wait.
// The rate is set by the combinational parallel compare of the window against the pattern.
// Reset clears the configuration registers, the entry state, the row counter and the result queue.
// Configuration writes complete in the cycle they are presented.
module column_substring_filter_unit #(
	parameter int PATTERN_MAX = 16,
	parameter int ROW_BITS    = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     character,
	input  logic                           has_character,
	input  logic                           end_of_entry,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [csf_pkg::OUT_W-1:0]      matching_row,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [1:0]                     cfg_index,
	input  logic [csf_pkg::CFG_DATA_W-1:0] cfg_data
);

	csf_pkg::cfg_t    cfg_q;
	csf_pkg::result_t res;
	logic             accept;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (csf_pkg::reg_idx_t'(cfg_index))
				csf_pkg::REG_PATTERN_LOW: begin
					cfg_q.pattern_low <= cfg_data;
				end
				csf_pkg::REG_PATTERN_HIGH: begin
					cfg_q.pattern_high <= cfg_data;
				end
				csf_pkg::REG_PATTERN_LENGTH: begin
					cfg_q.pattern_length <= cfg_data[csf_pkg::LEN_W-1:0];
				end
				csf_pkg::REG_FOLD_CASE: begin
					cfg_q.fold_case <= cfg_data[0];
				end
			endcase
		end
	end

	csf_match #(
		.PATTERN_MAX (PATTERN_MAX),
		.ROW_BITS    (ROW_BITS)
	) u_match (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.character     (character),
		.has_character (has_character),
		.end_of_entry  (end_of_entry),
		.cfg           (cfg_q),
		.res           (res)
	);

	csf_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res),
		.not_full  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (matching_row)
	);

endmodule
